@@ src/lsfd_pkg.sv @@
// ----------------------------------------------------------------------------
// lsfd_pkg
// Shared types and constants for the serial frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lsfd_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_SYNC_FIRST    = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND   = 2'd1;
  localparam logic [1:0] REG_GARBAGE_LIMIT = 2'd2;

  // Register reset values
  localparam logic [7:0] SYNC_FIRST_RST    = 8'h5A;
  localparam logic [7:0] SYNC_SECOND_RST   = 8'hA5;
  localparam logic [7:0] GARBAGE_LIMIT_RST = 8'd16;

  // Frame format limits
  localparam logic [7:0] CMD_LOW  = 8'h80;
  localparam logic [7:0] CMD_HIGH = 8'h84;
  localparam logic [7:0] MIN_LEN  = 8'd3;

  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_NO_SYNC  = 3'd1,
    KIND_BAD_SYNC = 3'd2,
    KIND_BAD_LEN  = 3'd3,
    KIND_BAD_CMD  = 3'd4
  } kind_e;

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_SYNC2   = 5'b00010,
    PH_LENGTH  = 5'b00100,
    PH_COMMAND = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] garbage_limit;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] command;
    logic [7:0] index;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

@@ src/lsfd_parser.sv @@
// ----------------------------------------------------------------------------
// lsfd_parser
// Frame parser state machine: one received byte per step, at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfd_parser
  import lsfd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire cfg_t       cfg_i,
  output result_t         res_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] garbage_q, garbage_d;
  logic [7:0] length_q, length_d;
  logic [7:0] taken_q, taken_d;
  logic [7:0] command_q, command_d;

  always_comb begin
    logic [7:0] taken_inc;
    taken_inc = taken_q + 8'd1;

    phase_d   = phase_q;
    garbage_d = garbage_q;
    length_d  = length_q;
    taken_d   = taken_q;
    command_d = command_q;

    res_o         = '0;
    res_o.kind    = KIND_PAYLOAD;
    res_o.data    = byte_i;

    case (phase_q)
      PH_SYNC2: begin
        if (byte_i != cfg_i.sync_second) begin
          res_o.valid = 1'b1;
          res_o.kind  = KIND_BAD_SYNC;
          phase_d     = PH_HUNT;
        end else begin
          phase_d = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (byte_i < MIN_LEN) begin
          res_o.valid = 1'b1;
          res_o.kind  = KIND_BAD_LEN;
          phase_d     = PH_HUNT;
        end else begin
          length_d = byte_i;
          phase_d  = PH_COMMAND;
        end
      end
      PH_COMMAND: begin
        if (byte_i < CMD_LOW || byte_i > CMD_HIGH) begin
          res_o.valid = 1'b1;
          res_o.kind  = KIND_BAD_CMD;
          phase_d     = PH_HUNT;
        end else begin
          command_d = byte_i;
          taken_d   = 8'd1;
          phase_d   = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res_o.valid   = 1'b1;
        res_o.command = command_q;
        res_o.index   = taken_q - 8'd1;
        res_o.last    = (taken_inc == length_q);
        taken_d       = taken_inc;
        if (taken_inc == length_q) begin
          phase_d = PH_HUNT;
        end
      end
      default: begin
        // hunt, also any unused phase code
        phase_d = PH_HUNT;
        if (byte_i == cfg_i.sync_first) begin
          garbage_d = '0;
          phase_d   = PH_SYNC2;
        end else if (garbage_q >= cfg_i.garbage_limit) begin
          garbage_d   = '0;
          res_o.valid = 1'b1;
          res_o.kind  = KIND_NO_SYNC;
        end else begin
          garbage_d = garbage_q + 8'd1;
        end
      end
    endcase

    if (!step_i) begin
      res_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      garbage_q <= '0;
      length_q  <= '0;
      taken_q   <= '0;
      command_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      garbage_q <= garbage_d;
      length_q  <= length_d;
      taken_q   <= taken_d;
      command_q <= command_d;
    end
  end

endmodule

`default_nettype wire

@@ src/lsfd_out_reg.sv @@
// ----------------------------------------------------------------------------
// lsfd_out_reg
// Result register toward the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfd_out_reg
  import lsfd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  input  wire logic    out_ready_i,
  output logic         out_valid_o,
  output result_t      data_o
);

  logic    valid_q;
  result_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_i.valid;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.valid) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign data_o      = data_q;

endmodule

`default_nettype wire

@@ src/lcd_serial_frame_deframer_top.sv @@
// ----------------------------------------------------------------------------
// lcd_serial_frame_deframer_top
// Recovers SYNC1 SYNC2 LEN CMD payload frames from a received byte stream.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                        Dir
//  -------   ---------------------------------------------  ---
//  rx byte   in_valid_i / in_ready_o, rx_byte_i             in
//  result    out_valid_o / out_ready_i, result_kind_o,      out
//            payload_byte_o, frame_command_o,
//            payload_index_o, frame_last_o
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i               in
//
//  One byte per cycle sustained while results are taken. A byte transfer
//  lands in an input register; in the next cycle the parser state machine
//  consumes it and the following edge loads the result register, which
//  drives out_valid_o, so a result goes out behind both registers.
//  Reset puts the parser in sync hunt and the registers at 0x5A, 0xA5, 16.
//  A stalled result register holds the input register, which then drops
//  in_ready_o; no bytes are lost or dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_serial_frame_deframer_top
  import lsfd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // received bytes
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  // results
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [2:0]      result_kind_o,
  output logic [7:0]      payload_byte_o,
  output logic [7:0]      frame_command_o,
  output logic [7:0]      payload_index_o,
  output logic            frame_last_o,
  // configuration writes
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i
);

  // Configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first    <= SYNC_FIRST_RST;
      cfg_q.sync_second   <= SYNC_SECOND_RST;
      cfg_q.garbage_limit <= GARBAGE_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SYNC_FIRST:    cfg_q.sync_first    <= cfg_wdata_i;
        REG_SYNC_SECOND:   cfg_q.sync_second   <= cfg_wdata_i;
        REG_GARBAGE_LIMIT: cfg_q.garbage_limit <= cfg_wdata_i;
        default: ; // unmapped index: ignored
      endcase
    end
  end

  // Input register. It advances whenever the result register is free or
  // is being drained this cycle, whether or not the byte yields a result.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       advance;

  assign advance    = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Parser: state update and result decode in one step
  result_t res;

  lsfd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Result register
  result_t out_data;

  lsfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .data_o      (out_data)
  );

  assign result_kind_o   = out_data.kind;
  assign payload_byte_o  = out_data.data;
  assign frame_command_o = out_data.command;
  assign payload_index_o = out_data.index;
  assign frame_last_o    = out_data.last;

`ifndef NO_ASSERTIONS
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> result_kind_o <= KIND_BAD_CMD)
    else $error("result kind out of range");

  a_last_is_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> result_kind_o == KIND_PAYLOAD)
    else $error("last flag on an error result");

  a_error_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != KIND_PAYLOAD
      |-> frame_command_o == 8'd0 && payload_index_o == 8'd0)
    else $error("error result carries frame fields");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire

@@ bench/lcd_serial_frame_deframer_top_tb.sv @@
// ----------------------------------------------------------------------------
// lcd_serial_frame_deframer_top_tb
// Self-checking bench for the serial frame deframer. A scoreboard keeps its
// own copy of the parser state and registers, predicts the result of every
// byte transfer, and checks each result transfer in order. Directed frames
// and error cases come first, then randomized segments; the register setting
// changes each two segments, the sender gap and receiver stall mix each segment.
// ----------------------------------------------------------------------------

module lcd_serial_frame_deframer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsfd_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400_000; // hard stop for a hung run
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned SEGMENTS     = 8;
  localparam int unsigned SEG_ITEMS    = 220;     // at least 1760 random bytes overall
  localparam int unsigned LONG_STALL   = 300;

  // One expected result transfer
  typedef struct {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] command;
    logic [7:0] index;
    logic       last;
  } deframed_t;

  // --------------------------------------------------------------------------
  // Scoreboard: frame parser prediction plus in-order result checking
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    // register copies
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] garbage_limit;
    // parser copy
    phase_e     phase;
    logic [7:0] garbage_count;
    logic [7:0] frame_length;
    logic [7:0] bytes_taken;
    logic [7:0] current_command;

    deframed_t   expected_q[$];
    int unsigned errors;

    function new();
      sync_first      = SYNC_FIRST_RST;
      sync_second     = SYNC_SECOND_RST;
      garbage_limit   = GARBAGE_LIMIT_RST;
      phase           = PH_HUNT;
      garbage_count   = '0;
      frame_length    = '0;
      bytes_taken     = '0;
      current_command = '0;
      errors          = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_SYNC_FIRST:    sync_first    = val;
        REG_SYNC_SECOND:   sync_second   = val;
        REG_GARBAGE_LIMIT: garbage_limit = val;
        default: ;
      endcase
    endfunction

    // any error consumes its byte and sends the parser back to the hunt
    function void push_error(kind_e kind, logic [7:0] b);
      deframed_t r;
      r.kind    = kind;
      r.data    = b;
      r.command = '0;
      r.index   = '0;
      r.last    = 1'b0;
      expected_q.insert(expected_q.size(), r);
      phase = PH_HUNT;
    endfunction

    // one accepted byte in, at most one expected result out
    function void note_byte(logic [7:0] b);
      deframed_t r;
      case (phase)
        PH_SYNC2: begin
          if (b != sync_second) push_error(KIND_BAD_SYNC, b);
          else phase = PH_LENGTH;
        end
        PH_LENGTH: begin
          if (b < MIN_LEN) begin
            push_error(KIND_BAD_LEN, b);
          end else begin
            frame_length = b;
            phase        = PH_COMMAND;
          end
        end
        PH_COMMAND: begin
          if (b < CMD_LOW || b > CMD_HIGH) begin
            push_error(KIND_BAD_CMD, b);
          end else begin
            current_command = b;
            bytes_taken     = 8'd1;
            phase           = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          r.kind      = KIND_PAYLOAD;
          r.data      = b;
          r.command   = current_command;
          r.index     = bytes_taken - 8'd1;
          bytes_taken = bytes_taken + 8'd1;
          r.last      = (bytes_taken == frame_length);
          expected_q.insert(expected_q.size(), r);
          if (r.last) phase = PH_HUNT;
        end
        default: begin
          phase = PH_HUNT;
          if (b == sync_first) begin
            garbage_count = '0;
            phase         = PH_SYNC2;
          end else if (garbage_count >= garbage_limit) begin
            garbage_count = '0;
            push_error(KIND_NO_SYNC, b);
          end else begin
            garbage_count = garbage_count + 8'd1;
          end
        end
      endcase
    endfunction

    function void check_result(logic [2:0] kind, logic [7:0] data, logic [7:0] command,
                               logic [7:0] index, logic last);
      deframed_t want;
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing pending: kind %0d byte 0x%02h", kind, data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (kind !== want.kind) begin
        $error("result_kind: expected %0d, got %0d", want.kind, kind);
        errors++;
      end
      if (data !== want.data) begin
        $error("payload_byte: expected 0x%02h, got 0x%02h", want.data, data);
        errors++;
      end
      if (command !== want.command) begin
        $error("frame_command: expected 0x%02h, got 0x%02h", want.command, command);
        errors++;
      end
      if (index !== want.index) begin
        $error("payload_index: expected %0d, got %0d", want.index, index);
        errors++;
      end
      if (last !== want.last) begin
        $error("frame_last: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] result_kind_o;
  logic [7:0] payload_byte_o;
  logic [7:0] frame_command_o;
  logic [7:0] payload_index_o;
  logic       frame_last_o;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_idx_i   = '0;
  logic [7:0] cfg_wdata_i = '0;

  lcd_serial_frame_deframer_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .payload_byte_o (payload_byte_o),
    .frame_command_o(frame_command_o),
    .payload_index_o(payload_index_o),
    .frame_last_o   (frame_last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  frame_scoreboard sb;
  int unsigned     items_sent     = 0;
  int unsigned     send_idle_pct  = 0;  // chance per cycle the sender holds back
  int unsigned     recv_stall_pct = 0;  // chance per cycle the receiver stalls
  int unsigned     stall_request  = 0;  // long receiver hold-off, picked up below
  int unsigned     stall_left     = 0;
  int unsigned     cycle_count    = 0;

  // --------------------------------------------------------------------------
  // Monitor: both channels sampled at the rising edge. A result always trails
  // its byte through the input and result registers, so call order is moot.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_byte(rx_byte_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(result_kind_o, payload_byte_o, frame_command_o,
                        payload_index_o, frame_last_o);
    end
  end

  // Receiver: random stalls, or a long hold-off counted down here so the
  // sender keeps pushing until the block backs up into in_ready_o.
  always @(negedge clk_i) begin
    if (stall_request != 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("lcd_serial_frame_deframer_top_tb NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers; all called at a falling edge and return at one
  // --------------------------------------------------------------------------

  // One byte transfer. Valid stays up afterwards so back-to-back bytes never
  // see valid dropped and raised in the same step.
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Sender goes quiet until every predicted result has been seen, then waits
  // out SETTLE in case the last byte was one that yields no result.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // Only while idle. The extra wait with cfg_we_i low keeps consecutive writes apart.
  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_config(input logic [7:0] s1, input logic [7:0] s2,
                              input logic [7:0] limit);
    cfg_write(REG_SYNC_FIRST, s1);
    cfg_write(REG_SYNC_SECOND, s2);
    cfg_write(REG_GARBAGE_LIMIT, limit);
  endtask

  // Mostly well-formed frames with random content, plus broken headers,
  // garbage runs sized around the current limit, and raw noise.
  task automatic random_traffic(input int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    int unsigned run;
    logic [7:0]  b;
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 64) begin
        // good frame; long ones are rare to keep the run short
        pick = $urandom_range(0, 99);
        if (pick < 85)      len = $urandom_range(3, 12);
        else if (pick < 97) len = $urandom_range(13, 64);
        else if (pick < 99) len = $urandom_range(65, 254);
        else                len = 255;
        push_byte(sb.sync_first);
        push_byte(sb.sync_second);
        push_byte(8'(len));
        push_byte(CMD_LOW + 8'($urandom_range(0, 4)));
        repeat (len - 1) push_byte(8'($urandom));
      end else if (pick < 71) begin
        // wrong second sync
        b = 8'($urandom);
        if (b == sb.sync_second) b = b ^ 8'h01;
        push_byte(sb.sync_first);
        push_byte(b);
      end else if (pick < 78) begin
        // length too short
        push_byte(sb.sync_first);
        push_byte(sb.sync_second);
        push_byte(8'($urandom_range(0, 2)));
      end else if (pick < 86) begin
        // command outside 0x80..0x84
        b = 8'($urandom_range(0, 250));
        if (b >= CMD_LOW) b = b + 8'd5;
        push_byte(sb.sync_first);
        push_byte(sb.sync_second);
        push_byte(8'($urandom_range(3, 12)));
        push_byte(b);
      end else if (pick < 94) begin
        // garbage run, long enough to trip the limit now and then
        run = $urandom_range(0, sb.garbage_limit + 2);
        repeat (run) begin
          b = 8'($urandom);
          if (b == sb.sync_first) b = b ^ 8'h01;
          push_byte(b);
        end
      end else begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] seq_q[$];

    sb = new();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, reset register values
    send_idle_pct  = 28;
    recv_stall_pct = 28;
    seq_q = '{8'h5A, 8'hA5, 8'h03, 8'h80, 8'h00, 8'hFF,   // shortest frame, lowest cmd
              8'h5A, 8'h00,                               // bad second sync
              8'h5A, 8'hA5, 8'h02,                        // length just too short
              8'h5A, 8'hA5, 8'hFF, 8'h85,                 // cmd just above range
              8'h5A, 8'hA5, 8'h04, 8'h7F};                // cmd just below range
    foreach (seq_q[i]) push_byte(seq_q[i]);
    wait_drained();

    // Limit of one: sync clears the garbage count, the second stray byte
    // after that reports no-sync.
    cfg_write(REG_GARBAGE_LIMIT, 8'd1);
    seq_q = '{8'h11, 8'h5A, 8'h00, 8'h22, 8'h33, 8'h5A};
    foreach (seq_q[i]) push_byte(seq_q[i]);
    wait_drained();

    // Parser sits waiting for the second sync; new value applies to the
    // very next byte. Payload carries the old sync values.
    cfg_write(REG_SYNC_SECOND, 8'h3C);
    seq_q = '{8'h3C, 8'h03, 8'h84, 8'h5A, 8'hA5};
    foreach (seq_q[i]) push_byte(seq_q[i]);

    // Random segments: register setting changes every two segments, idle
    // mix rotates every segment.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_drained();
      case ((seg / 2) % 4)
        0: write_config(SYNC_FIRST_RST, SYNC_SECOND_RST, GARBAGE_LIMIT_RST);
        1: write_config(8'h00, 8'hFF, 8'd0);      // every stray byte reports
        2: write_config(8'hFF, 8'h00, 8'd255);    // widest tolerance
        default: write_config(8'($urandom), 8'($urandom), 8'($urandom_range(0, 6)));
      endcase
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      // full-rate sender against a frozen receiver: block must back up
      if (seg == 4) stall_request = LONG_STALL;
      random_traffic(SEG_ITEMS);
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("lcd_serial_frame_deframer_top_tb OK");
    end else begin
      $display("lcd_serial_frame_deframer_top_tb NOT OK");
    end
    $finish;
  end

endmodule
